>>> design/sphc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphc_pkg
// Shared widths, codes and control structs of the stepper pulse controller.
// ----------------------------------------------------------------------------
package sphc_pkg;

    localparam int TICK_W  = 27;
    localparam int FREQ_W  = 21;
    localparam int CNT_W   = 24;
    localparam int STEPS_W = 32;
    localparam int CFG_W   = 27;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_STEP_COUNT_WIDTH = 32;
    localparam int DEF_PERIOD_WIDTH     = 32;

    localparam logic [TICK_W-1:0] RST_TICK_HZ       = 27'd4000000;
    localparam logic [FREQ_W-1:0] RST_JOG_FREQ     = 21'd80000;
    localparam logic [CNT_W-1:0]  RST_SETTLE_TICKS = 24'd40000;
    localparam logic [CNT_W-1:0]  RST_LOCKOUT      = 24'd100000;
    localparam logic [FREQ_W-1:0] RST_HOME_START   = 21'd32768;
    localparam logic [FREQ_W-1:0] RST_HOME_END     = 21'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_HZ     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JOG_FREQ    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_START  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_END    = 3'd5;

    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_HOME = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_JOG  = 2'd2,
        MODE_HOME = 2'd3
    } run_mode_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_RISE_PRE  = 3'd1,
        PH_RISE_POST = 3'd2,
        PH_FALL_PRE  = 3'd3,
        PH_FALL_POST = 3'd4
    } home_phase_t;

    typedef struct packed {
        logic load;       // capture input transaction
        logic eval;       // commands, jog, homing
        logic div_start;  // launch period division
        logic finish;     // pulse generator, result register
    } sphc_cmd_t;

    typedef struct packed {
        logic train_start; // eval step restarts a pulse train
        logic div_done;
    } sphc_status_t;

endpackage

>>> design/stepper_pulse_and_homing_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_pulse_and_homing_controller
// Step/direction pulse generator with move counting, jog buttons and
// end-switch homing. One input transaction is one timer tick.
// ----------------------------------------------------------------------------
// Sequence: an accepted tick is captured, evaluated and then finished into
//   the result register; a tick that (re)starts a pulse train first waits
//   for the 27-step period divider. A new transaction is taken only once the
//   last one is finished and the result register is free or being read.
// Reset: synchronous, active low; all state idle, config at its defaults.
// ----------------------------------------------------------------------------
module stepper_pulse_and_homing_controller #(
    parameter int STEP_COUNT_WIDTH = sphc_pkg::DEF_STEP_COUNT_WIDTH,
    parameter int PERIOD_WIDTH     = sphc_pkg::DEF_PERIOD_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [sphc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sphc_pkg::CFG_W-1:0]     cfg_wdata,
    // tick / command transaction
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_kind,
    input  logic                           s_move_dir,
    input  logic [sphc_pkg::STEPS_W-1:0]   s_move_steps,
    input  logic [sphc_pkg::FREQ_W-1:0]    s_move_freq,
    input  logic                           s_end_switch,
    input  logic                           s_cw_button,
    input  logic                           s_ccw_button,
    // per-tick result transaction
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_step_out,
    output logic                           m_dir_out,
    output logic                           m_busy_res,
    output logic                           m_done_res,
    output logic                           m_cw_led,
    output logic                           m_ccw_led,
    output logic                           m_rejected
);

    // Controller walks each tick through capture, evaluation (commands,
    // jog, homing), an optional period division, and the pulse-generator
    // update that also loads the result register.
    sphc_pkg::sphc_cmd_t    cmd;
    sphc_pkg::sphc_status_t status;

    sphc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Datapath holds config, motion state, the divider and the result register.
    sphc_datapath #(
        .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH),
        .PERIOD_WIDTH     (PERIOD_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_kind       (s_kind),
        .s_move_dir   (s_move_dir),
        .s_move_steps (s_move_steps),
        .s_move_freq  (s_move_freq),
        .s_end_switch (s_end_switch),
        .s_cw_button  (s_cw_button),
        .s_ccw_button (s_ccw_button),
        .m_step_out   (m_step_out),
        .m_dir_out    (m_dir_out),
        .m_busy_res   (m_busy_res),
        .m_done_res   (m_done_res),
        .m_cw_led     (m_cw_led),
        .m_ccw_led    (m_ccw_led),
        .m_rejected   (m_rejected)
    );

endmodule

>>> design/sphc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphc_div
// Restoring divider, one quotient bit per cycle: tick rate / frequency.
// ----------------------------------------------------------------------------
module sphc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [sphc_pkg::TICK_W-1:0]  dividend,
    input  logic [sphc_pkg::FREQ_W-1:0]  divisor,
    output logic                         done,
    output logic [sphc_pkg::TICK_W-1:0]  quotient
);

    localparam int TW = sphc_pkg::TICK_W;
    localparam int FW = sphc_pkg::FREQ_W;
    localparam int CW = $clog2(TW);

    logic [FW-1:0] rem_reg, dvs_reg;
    logic [TW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [FW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[TW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(TW - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? FW'(trial - {1'b0, dvs_reg}) : trial[FW-1:0];
            quo_reg <= {quo_reg[TW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/sphc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphc_datapath
// Config registers, motion state, period divider and the result register.
// ----------------------------------------------------------------------------
module sphc_datapath #(
    parameter int STEP_COUNT_WIDTH = sphc_pkg::DEF_STEP_COUNT_WIDTH,
    parameter int PERIOD_WIDTH     = sphc_pkg::DEF_PERIOD_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sphc_pkg::sphc_cmd_t            cmd,
    output sphc_pkg::sphc_status_t         status,
    input  logic                           cfg_wr_en,
    input  logic [sphc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sphc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [1:0]                     s_kind,
    input  logic                           s_move_dir,
    input  logic [sphc_pkg::STEPS_W-1:0]   s_move_steps,
    input  logic [sphc_pkg::FREQ_W-1:0]    s_move_freq,
    input  logic                           s_end_switch,
    input  logic                           s_cw_button,
    input  logic                           s_ccw_button,
    output logic                           m_step_out,
    output logic                           m_dir_out,
    output logic                           m_busy_res,
    output logic                           m_done_res,
    output logic                           m_cw_led,
    output logic                           m_ccw_led,
    output logic                           m_rejected
);

    localparam int TW  = sphc_pkg::TICK_W;
    localparam int FW  = sphc_pkg::FREQ_W;
    localparam int NW  = sphc_pkg::CNT_W;
    localparam int IW  = sphc_pkg::STEPS_W;
    localparam int SW  = STEP_COUNT_WIDTH;
    localparam int PW  = PERIOD_WIDTH;
    localparam int QW  = (PW > TW) ? PW : TW;
    localparam int SXW = (SW > IW) ? SW : IW;

    // configuration
    logic [TW-1:0] tick_hz_reg;
    logic [FW-1:0] jog_freq_reg, home_start_reg, home_end_reg;
    logic [NW-1:0] settle_ticks_reg, lockout_reg;

    // captured transaction
    logic [1:0]    kind_reg;
    logic          mdir_reg, es_reg, cwb_reg, ccwb_reg;
    logic [IW-1:0] msteps_reg;
    logic [FW-1:0] mfreq_reg;

    // motion state
    sphc_pkg::run_mode_t   mode_reg;
    sphc_pkg::home_phase_t phase_reg;
    logic          pulsing_reg, dir_reg;
    logic [PW-1:0] plen_reg, pcnt_reg;
    logic [SW-1:0] steps_reg;
    logic [FW-1:0] freq_reg;
    logic [NW-1:0] settle_reg, cwl_reg, ccwl_reg;
    logic [1:0]    btn_prev_reg;
    logic          start_pend_reg, done_pend_reg, rej_pend_reg;

    // eval results
    sphc_pkg::run_mode_t   v_mode;
    sphc_pkg::home_phase_t v_phase;
    logic          v_puls, v_dir, v_done, v_rej, v_st, v_cmd, v_target;
    logic [FW-1:0] v_freq, v_endf;
    logic [SW-1:0] v_steps;
    logic [NW-1:0] v_settle, v_cwl, v_ccwl;
    logic [SXW-1:0] v_msteps_ext;

    logic          div_done;
    logic [TW-1:0] quotient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_hz_reg      <= sphc_pkg::RST_TICK_HZ;
            jog_freq_reg     <= sphc_pkg::RST_JOG_FREQ;
            settle_ticks_reg <= sphc_pkg::RST_SETTLE_TICKS;
            lockout_reg      <= sphc_pkg::RST_LOCKOUT;
            home_start_reg   <= sphc_pkg::RST_HOME_START;
            home_end_reg     <= sphc_pkg::RST_HOME_END;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sphc_pkg::CFG_TICK_HZ:    tick_hz_reg      <= cfg_wdata[TW-1:0];
                sphc_pkg::CFG_JOG_FREQ:   jog_freq_reg     <= cfg_wdata[FW-1:0];
                sphc_pkg::CFG_SETTLE:     settle_ticks_reg <= cfg_wdata[NW-1:0];
                sphc_pkg::CFG_LOCKOUT:    lockout_reg      <= cfg_wdata[NW-1:0];
                sphc_pkg::CFG_HOME_START: home_start_reg   <= cfg_wdata[FW-1:0];
                sphc_pkg::CFG_HOME_END:   home_end_reg     <= cfg_wdata[FW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= s_kind;
            mdir_reg   <= s_move_dir;
            msteps_reg <= s_move_steps;
            mfreq_reg  <= s_move_freq;
            es_reg     <= s_end_switch;
            cwb_reg    <= s_cw_button;
            ccwb_reg   <= s_ccw_button;
        end
    end

    // command, jog and homing for one tick, in that order
    always_comb begin
        v_mode   = mode_reg;
        v_phase  = phase_reg;
        v_puls   = pulsing_reg;
        v_dir    = dir_reg;
        v_freq   = freq_reg;
        v_steps  = steps_reg;
        v_settle = settle_reg;
        v_done   = 1'b0;
        v_rej    = 1'b0;
        v_st     = 1'b0;
        v_cmd    = 1'b0;
        v_cwl    = (cwl_reg != '0) ? cwl_reg - 1'b1 : cwl_reg;
        v_ccwl   = (ccwl_reg != '0) ? ccwl_reg - 1'b1 : ccwl_reg;
        v_endf   = (home_end_reg != '0) ? home_end_reg : FW'(1);
        v_msteps_ext = SXW'(msteps_reg);

        if (kind_reg == sphc_pkg::KIND_MOVE || kind_reg == sphc_pkg::KIND_HOME) begin
            v_cmd = 1'b1;
            if (mode_reg != sphc_pkg::MODE_IDLE) begin
                v_rej = 1'b1;
            end else if (kind_reg == sphc_pkg::KIND_MOVE) begin
                if (msteps_reg == '0) begin
                    v_done = 1'b1;
                end else begin
                    if (v_msteps_ext > SXW'({SW{1'b1}})) begin
                        v_steps = {SW{1'b1}};
                    end else begin
                        v_steps = SW'(v_msteps_ext);
                    end
                    v_mode = sphc_pkg::MODE_MOVE;
                    v_st   = 1'b1;
                    v_puls = 1'b1;
                    v_dir  = mdir_reg;
                    v_freq = (mfreq_reg != '0) ? mfreq_reg : FW'(1);
                end
            end else begin
                v_mode  = sphc_pkg::MODE_HOME;
                v_phase = es_reg ? sphc_pkg::PH_FALL_PRE : sphc_pkg::PH_RISE_PRE;
                v_st    = 1'b1;
                v_puls  = 1'b1;
                v_dir   = es_reg;
                v_freq  = (home_start_reg != '0) ? home_start_reg : FW'(1);
            end
        end

        if (!v_cmd && v_mode == sphc_pkg::MODE_IDLE) begin
            if (!cwb_reg && btn_prev_reg[0] && v_cwl == '0) begin
                v_mode = sphc_pkg::MODE_JOG;
                v_cwl  = lockout_reg;
                v_st   = 1'b1;
                v_puls = 1'b1;
                v_dir  = 1'b0;
                v_freq = (jog_freq_reg != '0) ? jog_freq_reg : FW'(1);
            end else if (!ccwb_reg && btn_prev_reg[1] && v_ccwl == '0) begin
                v_mode = sphc_pkg::MODE_JOG;
                v_ccwl = lockout_reg;
                v_st   = 1'b1;
                v_puls = 1'b1;
                v_dir  = 1'b1;
                v_freq = (jog_freq_reg != '0) ? jog_freq_reg : FW'(1);
            end
        end else if (v_mode == sphc_pkg::MODE_JOG) begin
            if (!v_dir && cwb_reg && v_cwl == '0) begin
                v_mode = sphc_pkg::MODE_IDLE;
                v_puls = 1'b0;
                v_cwl  = lockout_reg;
            end else if (v_dir && ccwb_reg && v_ccwl == '0) begin
                v_mode = sphc_pkg::MODE_IDLE;
                v_puls = 1'b0;
                v_ccwl = lockout_reg;
            end
        end

        v_target = ~v_dir;
        if (v_mode == sphc_pkg::MODE_HOME) begin
            if (v_phase == sphc_pkg::PH_RISE_PRE || v_phase == sphc_pkg::PH_FALL_PRE) begin
                if (es_reg == v_target) begin
                    v_puls   = 1'b0;
                    v_settle = settle_ticks_reg;
                    v_phase  = (v_phase == sphc_pkg::PH_RISE_PRE) ?
                               sphc_pkg::PH_RISE_POST : sphc_pkg::PH_FALL_POST;
                end
            end else if (v_settle != '0) begin
                v_settle = v_settle - 1'b1;
            end else if (es_reg != v_target) begin
                v_phase = (v_phase == sphc_pkg::PH_RISE_POST) ?
                          sphc_pkg::PH_RISE_PRE : sphc_pkg::PH_FALL_PRE;
                v_st   = 1'b1;
                v_puls = 1'b1;
                v_freq = (v_freq != '0) ? v_freq : FW'(1);
            end else if (v_phase == sphc_pkg::PH_RISE_POST) begin
                v_phase = sphc_pkg::PH_FALL_PRE;
                v_st    = 1'b1;
                v_puls  = 1'b1;
                v_dir   = ~v_dir;
                v_freq  = (v_freq != '0) ? v_freq : FW'(1);
            end else if (v_freq > v_endf) begin
                v_phase = sphc_pkg::PH_FALL_PRE;
                v_st    = 1'b1;
                v_puls  = 1'b1;
                v_dir   = ~v_dir;
                v_freq  = (v_freq[FW-1:1] != '0) ? {1'b0, v_freq[FW-1:1]} : FW'(1);
            end else begin
                v_phase = sphc_pkg::PH_IDLE;
                v_mode  = sphc_pkg::MODE_IDLE;
                v_puls  = 1'b0;
                v_done  = 1'b1;
            end
        end
    end

    assign status.train_start = v_st;
    assign status.div_done    = div_done;

    sphc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (tick_hz_reg),
        .divisor  (v_freq),
        .done     (div_done),
        .quotient (quotient)
    );

    // period clamp to [2, PERIOD max]
    logic [QW-1:0] q_ext;
    logic [PW-1:0] plen_new, plen_eff;
    logic [PW:0]   pcnt_inc;
    logic          p_step, p_wrap;
    logic [SW-1:0] steps_dec;

    always_comb begin
        q_ext = QW'(quotient);
        if (q_ext < QW'(2)) begin
            plen_new = PW'(2);
        end else if (q_ext > QW'({PW{1'b1}})) begin
            plen_new = {PW{1'b1}};
        end else begin
            plen_new = PW'(q_ext);
        end
        plen_eff  = start_pend_reg ? plen_new : plen_reg;
        p_step    = pcnt_reg >= (plen_eff >> 1);
        pcnt_inc  = {1'b0, pcnt_reg} + 1'b1;
        p_wrap    = pcnt_inc >= {1'b0, plen_eff};
        steps_dec = (steps_reg != '0) ? steps_reg - 1'b1 : steps_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= sphc_pkg::MODE_IDLE;
            phase_reg      <= sphc_pkg::PH_IDLE;
            pulsing_reg    <= 1'b0;
            dir_reg        <= 1'b0;
            plen_reg       <= '0;
            pcnt_reg       <= '0;
            steps_reg      <= '0;
            freq_reg       <= '0;
            settle_reg     <= '0;
            cwl_reg        <= '0;
            ccwl_reg       <= '0;
            btn_prev_reg   <= 2'b11;
            start_pend_reg <= 1'b0;
            done_pend_reg  <= 1'b0;
            rej_pend_reg   <= 1'b0;
        end else if (cmd.eval) begin
            mode_reg       <= v_mode;
            phase_reg      <= v_phase;
            pulsing_reg    <= v_puls;
            dir_reg        <= v_dir;
            freq_reg       <= v_freq;
            steps_reg      <= v_steps;
            settle_reg     <= v_settle;
            cwl_reg        <= v_cwl;
            ccwl_reg       <= v_ccwl;
            btn_prev_reg   <= {ccwb_reg, cwb_reg};
            start_pend_reg <= v_st;
            done_pend_reg  <= v_done;
            rej_pend_reg   <= v_rej;
            if (v_st) begin
                pcnt_reg <= '0;
            end
        end else if (cmd.finish) begin
            start_pend_reg <= 1'b0;
            if (start_pend_reg) begin
                plen_reg <= plen_new;
            end
            if (pulsing_reg) begin
                if (p_wrap) begin
                    pcnt_reg <= '0;
                    if (mode_reg == sphc_pkg::MODE_MOVE) begin
                        steps_reg <= steps_dec;
                        if (steps_dec == '0) begin
                            pulsing_reg <= 1'b0;
                            mode_reg    <= sphc_pkg::MODE_IDLE;
                        end
                    end
                end else begin
                    pcnt_reg <= pcnt_inc[PW-1:0];
                end
            end
        end
    end

    // result register
    logic fin_stop, fin_puls;
    assign fin_stop = pulsing_reg && p_wrap && mode_reg == sphc_pkg::MODE_MOVE
                      && steps_dec == '0;
    assign fin_puls = pulsing_reg && !fin_stop;

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_step_out <= pulsing_reg && p_step;
            m_dir_out  <= dir_reg;
            m_busy_res <= (mode_reg != sphc_pkg::MODE_IDLE) && !fin_stop;
            m_done_res <= done_pend_reg || fin_stop;
            m_cw_led   <= fin_puls && !dir_reg;
            m_ccw_led  <= fin_puls && dir_reg;
            m_rejected <= rej_pend_reg;
        end
    end

endmodule

>>> design/sphc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphc_ctrl
// Sequencer: capture, evaluate, optional division, finish and hand-off.
// ----------------------------------------------------------------------------
module sphc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sphc_pkg::sphc_cmd_t    cmd,
    input  sphc_pkg::sphc_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (status.train_start) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish   = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> dv/stepper_pulse_and_homing_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_pulse_and_homing_controller_test
// Self-checking bench for the stepper pulse controller. It drives per-tick
// transactions and tracks the controller state in a cycle-free tick model:
// moves, jog, homing and the pulse train. Every result transaction is checked
// field by field against the model.
// ----------------------------------------------------------------------------
module stepper_pulse_and_homing_controller_test;
    import sphc_pkg::*;

    typedef struct packed {
        logic [1:0]         kind;
        logic               dir;
        logic [STEPS_W-1:0] steps;
        logic [FREQ_W-1:0]  freq;
        logic               es;
        logic               cwb;
        logic               ccwb;
    } tick_t;

    typedef struct packed {
        logic step;
        logic dir;
        logic busy;
        logic done;
        logic cw_led;
        logic ccw_led;
        logic rej;
    } pin_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_kind = 2'd0;
    logic                 s_move_dir = 1'b0;
    logic [STEPS_W-1:0]   s_move_steps = '0;
    logic [FREQ_W-1:0]    s_move_freq = '0;
    logic                 s_end_switch = 1'b0;
    logic                 s_cw_button = 1'b1;
    logic                 s_ccw_button = 1'b1;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_step_out, m_dir_out, m_busy_res, m_done_res;
    logic                 m_cw_led, m_ccw_led, m_rejected;

    stepper_pulse_and_homing_controller u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---- tick model state, mirrors the controller ----
    logic [63:0] tick_hz = RST_TICK_HZ, jog_hz = RST_JOG_FREQ;
    logic [63:0] settle_len = RST_SETTLE_TICKS, lock_len = RST_LOCKOUT;
    logic [63:0] home_hi_hz = RST_HOME_START, home_lo_hz = RST_HOME_END;

    run_mode_t   mode = MODE_IDLE;
    home_phase_t phase = PH_IDLE;
    logic        train_on = 1'b0, dir_now = 1'b0;
    logic [31:0] per_len = '0, per_cnt = '0, steps_rem = '0, freq_now = '0;
    logic [23:0] settle_cnt = '0, cw_lock = '0, ccw_lock = '0;
    logic [1:0]  btn_last = 2'b11;

    tick_t pending_ticks[$];
    pin_t  expected_pins[$];

    int  errors = 0;
    bit  calm = 1'b0;       // no idling on either side
    bit  s_took = 1'b0;
    int  hold_cycles = 0;
    bit  pressure_done = 1'b0;
    int  results_seen = 0;

    // load a new pulse train: period = tick_hz / freq, clamped to >= 2
    task automatic launch_train(input logic d, input logic [63:0] hz);
        logic [63:0] f, p;
        f = (hz == 0) ? 64'd1 : hz;
        p = tick_hz / f;
        if (p < 2) p = 2;
        if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
        dir_now  = d;
        freq_now = f[31:0];
        per_len  = p[31:0];
        per_cnt  = '0;
        train_on = 1'b1;
    endtask

    task automatic advance_tick(input tick_t t, output pin_t r);
        logic        cmd, target;
        logic [63:0] endf;
        r   = '0;
        cmd = 1'b0;
        if (cw_lock != 0) cw_lock--;
        if (ccw_lock != 0) ccw_lock--;

        // commands; kind three is a plain tick
        if (t.kind == KIND_MOVE || t.kind == KIND_HOME) begin
            cmd = 1'b1;
            if (mode != MODE_IDLE) begin
                r.rej = 1'b1;
            end else if (t.kind == KIND_MOVE) begin
                if (t.steps == 0) begin
                    r.done = 1'b1;
                end else begin
                    steps_rem = t.steps;
                    mode = MODE_MOVE;
                    launch_train(t.dir, {43'd0, t.freq});
                end
            end else begin
                mode = MODE_HOME;
                if (t.es) begin
                    phase = PH_FALL_PRE;
                    launch_train(1'b1, home_hi_hz);
                end else begin
                    phase = PH_RISE_PRE;
                    launch_train(1'b0, home_hi_hz);
                end
            end
        end

        // jog buttons, active low, fresh press only
        if (!cmd && mode == MODE_IDLE) begin
            if (!t.cwb && btn_last[0] && cw_lock == 0) begin
                mode = MODE_JOG;
                cw_lock = lock_len[23:0];
                launch_train(1'b0, jog_hz);
            end else if (!t.ccwb && btn_last[1] && ccw_lock == 0) begin
                mode = MODE_JOG;
                ccw_lock = lock_len[23:0];
                launch_train(1'b1, jog_hz);
            end
        end else if (mode == MODE_JOG) begin
            if (!dir_now && t.cwb && cw_lock == 0) begin
                mode = MODE_IDLE;
                train_on = 1'b0;
                cw_lock = lock_len[23:0];
            end else if (dir_now && t.ccwb && ccw_lock == 0) begin
                mode = MODE_IDLE;
                train_on = 1'b0;
                ccw_lock = lock_len[23:0];
            end
        end

        // homing sequence
        if (mode == MODE_HOME) begin
            target = ~dir_now;
            if (phase == PH_RISE_PRE || phase == PH_FALL_PRE) begin
                if (t.es == target) begin
                    train_on = 1'b0;
                    settle_cnt = settle_len[23:0];
                    phase = (phase == PH_RISE_PRE) ? PH_RISE_POST : PH_FALL_POST;
                end
            end else if (settle_cnt != 0) begin
                settle_cnt--;
            end else if (t.es != target) begin
                phase = (phase == PH_RISE_POST) ? PH_RISE_PRE : PH_FALL_PRE;
                launch_train(dir_now, {32'd0, freq_now});
            end else if (phase == PH_RISE_POST) begin
                phase = PH_FALL_PRE;
                launch_train(~dir_now, {32'd0, freq_now});
            end else begin
                endf = (home_lo_hz == 0) ? 64'd1 : home_lo_hz;
                if ({32'd0, freq_now} > endf) begin
                    phase = PH_FALL_PRE;
                    launch_train(~dir_now, {33'd0, freq_now[31:1]});
                end else begin
                    phase = PH_IDLE;
                    mode = MODE_IDLE;
                    train_on = 1'b0;
                    r.done = 1'b1;
                end
            end
        end

        // pulse generator: high in the second half of the period
        if (train_on) begin
            r.step = (per_cnt >= (per_len >> 1));
            per_cnt++;
            if (per_cnt >= per_len) begin
                per_cnt = '0;
                if (mode == MODE_MOVE) begin
                    if (steps_rem != 0) steps_rem--;
                    if (steps_rem == 0) begin
                        train_on = 1'b0;
                        mode = MODE_IDLE;
                        r.done = 1'b1;
                    end
                end
            end
        end

        btn_last   = {t.ccwb, t.cwb};
        r.dir     = dir_now;
        r.busy    = (mode != MODE_IDLE);
        r.cw_led  = train_on && !dir_now;
        r.ccw_led = train_on && dir_now;
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // ---- driver: new transaction at the falling edge ----
    always @(posedge aclk) s_took <= s_valid && s_ready;

    always @(negedge aclk) begin
        tick_t t;
        if (aresetn && (!s_valid || s_took)) begin
            if (pending_ticks.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
                t = pending_ticks.pop_front();
                s_kind       <= t.kind;
                s_move_dir   <= t.dir;
                s_move_steps <= t.steps;
                s_move_freq  <= t.freq;
                s_end_switch <= t.es;
                s_cw_button  <= t.cwb;
                s_ccw_button <= t.ccwb;
                s_valid      <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---- receiver ready, with one long hold-off to back up the input ----
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (!pressure_done && results_seen >= 200) begin
            pressure_done <= 1'b1;
            hold_cycles <= 400;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    // ---- monitor: model on input accept, check on result accept ----
    always @(posedge aclk) begin
        tick_t t;
        pin_t  e, got;
        if (aresetn && s_valid && s_ready) begin
            t = '{s_kind, s_move_dir, s_move_steps, s_move_freq,
                  s_end_switch, s_cw_button, s_ccw_button};
            advance_tick(t, e);
            expected_pins.push_back(e);
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            got = '{m_step_out, m_dir_out, m_busy_res, m_done_res,
                    m_cw_led, m_ccw_led, m_rejected};
            if (expected_pins.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                e = expected_pins.pop_front();
                if (got.step != e.step)       report_mismatch("step_out");
                if (got.dir != e.dir)         report_mismatch("dir_out");
                if (got.busy != e.busy)       report_mismatch("busy_res");
                if (got.done != e.done)       report_mismatch("done_res");
                if (got.cw_led != e.cw_led)   report_mismatch("cw_led");
                if (got.ccw_led != e.ccw_led) report_mismatch("ccw_led");
                if (got.rej != e.rej)         report_mismatch("rejected");
            end
        end
    end

    // ---- stimulus helpers ----
    task automatic push_tick(input logic [1:0] k, input logic d, input logic [31:0] st,
                             input logic [20:0] f, input logic es, input logic cw,
                             input logic ccw);
        pending_ticks.push_back('{k, d, st, f, es, cw, ccw});
    endtask

    // all six registers, one write per cycle; model follows
    task automatic write_regs(input logic [63:0] v[6]);
        for (int i = 0; i < 6; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_wdata <= v[i][CFG_W-1:0];
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tick_hz    = v[CFG_TICK_HZ] & 64'h7FF_FFFF;
        jog_hz     = v[CFG_JOG_FREQ] & 64'h1F_FFFF;
        settle_len = v[CFG_SETTLE] & 64'hFF_FFFF;
        lock_len   = v[CFG_LOCKOUT] & 64'hFF_FFFF;
        home_hi_hz = v[CFG_HOME_START] & 64'h1F_FFFF;
        home_lo_hz = v[CFG_HOME_END] & 64'h1F_FFFF;
    endtask

    // wait for the pipe to drain, then past the longest latency
    task automatic drain;
        wait (pending_ticks.size() == 0 && expected_pins.size() == 0 && !s_valid);
        repeat (40) @(posedge aclk);
    endtask

    // random ticks: sticky switch and buttons so homing and jog make progress
    task automatic random_ticks(input int n);
        logic        es, cw, ccw;
        logic [1:0]  k;
        logic [31:0] st, lo, hi;
        logic [20:0] f;
        int          r;
        es = 1'b0; cw = 1'b1; ccw = 1'b1;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(5) == 0) es = ~es;
            if ($urandom_range(9) == 0) cw = ~cw;
            if ($urandom_range(9) == 0) ccw = ~ccw;
            r = $urandom_range(99);
            k = (r < 78) ? 2'd0 : (r < 90) ? KIND_MOVE : (r < 98) ? KIND_HOME : 2'd3;
            st = (k == KIND_MOVE) ? $urandom_range(12) : $urandom;
            hi = 32'(tick_hz / 2);
            if (hi > 2000000) hi = 2000000;
            lo = 32'(tick_hz / 20 + 1);
            if (lo > hi) lo = hi;
            f = ($urandom_range(3) == 0) ? 21'($urandom_range(2097151))
                                         : 21'($urandom_range(hi, lo));
            push_tick(k, 1'($urandom_range(1)), st, f, es, cw, ccw);
        end
    endtask

    initial begin
        logic [63:0] regs[6];
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // short periods so moves and homing finish in few ticks
        regs = '{1000, 200, 3, 5, 250, 60};
        write_regs(regs);

        // directed: zero step move, kind three, busy rejects, homing, jog
        push_tick(2'd0, 0, 32'd0, 21'd0, 0, 1, 1);
        push_tick(KIND_MOVE, 0, 32'd0, 21'd100, 0, 1, 1);
        push_tick(2'd3, 1, 32'hFFFF_FFFF, 21'h1F_FFFF, 1, 1, 1);
        push_tick(KIND_MOVE, 1, 32'd2, 21'h1F_FFFF, 0, 1, 1);
        push_tick(KIND_MOVE, 0, 32'd5, 21'd100, 0, 1, 1);
        push_tick(KIND_HOME, 0, 32'd0, 21'd0, 0, 1, 1);
        repeat (3) push_tick(2'd0, 0, 32'd0, 21'd0, 0, 1, 1);
        push_tick(KIND_HOME, 0, 32'd0, 21'd0, 0, 1, 1);
        repeat (5) push_tick(2'd0, 0, 32'd0, 21'd0, 0, 1, 1);
        repeat (6) push_tick(2'd0, 0, 32'd0, 21'd0, 1, 1, 1);
        repeat (3) push_tick(2'd0, 0, 32'd0, 21'd0, 0, 0, 0);
        repeat (3) push_tick(2'd0, 0, 32'd0, 21'd0, 0, 1, 0);
        random_ticks(380);
        drain();

        // fastest trains, zero settle and lockout, no idling
        calm = 1'b1;
        regs = '{1000, 1000, 0, 0, 2000000, 0};
        write_regs(regs);
        random_ticks(350);
        drain();
        calm = 1'b0;

        // high tick rate, longest lockout
        regs = '{100000000, 2000000, 20, 16777215, 2000000, 1000000};
        write_regs(regs);
        random_ticks(350);
        drain();

        // longest settle, slowest homing; ends in a move that never finishes
        regs = '{1000, 1, 16777215, 0, 1, 1};
        write_regs(regs);
        random_ticks(240);
        push_tick(KIND_MOVE, 1, 32'hFFFF_FFFF, 21'd0, 1, 1, 1);
        repeat (5) push_tick(2'd0, 0, 32'd0, 21'd0, 1, 1, 1);
        drain();

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
